// File: hw/rtl/mirror_tile_matrix_unit_defines.svh
// assertion macros used by the mirror tile matrix back end
`ifndef MIRROR_TILE_MATRIX_UNIT_DEFINES_SVH
`define MIRROR_TILE_MATRIX_UNIT_DEFINES_SVH

`define MTM_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

`define MTM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

`define MTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// File: hw/rtl/mtm_pkg.sv
// types and constants of the mirror tile matrix unit
`default_nettype none

package mtm_pkg;

   localparam int MAX_ROWS   = 32;
   localparam int MAX_COLS   = 32;
   localparam int DATA_WIDTH = 64;

   localparam int FIELD_W   = 64;
   localparam int COORD_W   = 7;
   localparam int DIM_CFG_W = 6;
   localparam int DIM_W     = 9;
   localparam int RA_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CA_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam int CSR_IDX_W = 2;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 2);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS = 2'd0,
      CSR_NUM_COLS = 2'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_READ,
      CMD_OOR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [ADDR_W-1:0]     addr;
      logic [DATA_WIDTH-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data;
      logic                  oor;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/mtm_front.sv
// front end: config registers, range checks and mirror folding of coordinates
`default_nettype none

module mtm_front
   import mtm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_CFG_W-1:0] csr_data,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic                 req_opcode,
   input  wire logic [COORD_W-1:0]   req_row,
   input  wire logic [COORD_W-1:0]   req_col,
   input  wire logic [FIELD_W-1:0]   req_element_value,
   input  wire logic                 q_full,
   output logic                      q_push,
   output cmd_type                   q_cmd
);

   logic [DIM_CFG_W-1:0] num_rows_ff, num_rows_in;
   logic [DIM_CFG_W-1:0] num_cols_ff, num_cols_in;
   logic [DIM_W-1:0]     m_eff, n_eff;
   logic [DIM_W-1:0]     r_ext, c_ext;
   logic [DIM_W-1:0]     sr_full, sc_full;
   logic [RA_W-1:0]      sr;
   logic [CA_W-1:0]      sc;
   logic                 wr_in_range, rd_in_range;
   logic                 accept;

   function automatic logic [DIM_W-1:0] fold(input logic [DIM_W-1:0] p,
                                             input logic [DIM_W-1:0] size);
      logic [DIM_W-1:0] size2;
      logic [DIM_W-1:0] size3;
      size2 = size << 1;
      size3 = size2 + size;
      if (p < size) begin
         fold = size - p - DIM_W'(1);
      end else if (p < size2) begin
         fold = p - size;
      end else begin
         fold = size3 - p - DIM_W'(1);
      end
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_ROWS: num_rows_in = csr_data;
            CSR_NUM_COLS: num_cols_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= '0;
         num_cols_ff <= '0;
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
      end
   end

   always_comb begin
      m_eff = (DIM_W'(num_rows_ff) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                      : DIM_W'(num_rows_ff);
      n_eff = (DIM_W'(num_cols_ff) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                      : DIM_W'(num_cols_ff);
      r_ext = DIM_W'(req_row);
      c_ext = DIM_W'(req_col);
      wr_in_range = (r_ext < m_eff) && (c_ext < n_eff);
      rd_in_range = (m_eff != '0) && (n_eff != '0)
                    && (r_ext < (m_eff + (m_eff << 1)))
                    && (c_ext < (n_eff + (n_eff << 1)));
      sr_full = fold(r_ext, m_eff);
      sc_full = fold(c_ext, n_eff);
      sr = sr_full[RA_W-1:0];
      sc = sc_full[CA_W-1:0];
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_comb begin
      q_cmd.data = req_element_value[DATA_WIDTH-1:0];
      if (req_opcode == OP_WRITE) begin
         q_cmd.kind = CMD_WRITE;
         q_cmd.addr = ADDR_W'(req_row) * ADDR_W'(MAX_COLS) + ADDR_W'(req_col);
         q_push     = accept && wr_in_range;
      end else begin
         q_cmd.kind = rd_in_range ? CMD_READ : CMD_OOR;
         q_cmd.addr = ADDR_W'(sr) * ADDR_W'(MAX_COLS) + ADDR_W'(sc);
         q_push     = accept;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/mtm_cmd_queue.sv
// short command queue between the front end and the back end
`default_nettype none

module mtm_cmd_queue
   import mtm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type cmd_in,
   output logic         full,
   output cmd_head_type head,
   input  wire logic    pop
);

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && head.valid;
      wr_ptr_in = do_push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/mtm_back.sv
// back end: element memory, read stage and result buffer
`default_nettype none
`include "mirror_tile_matrix_unit_defines.svh"

module mtm_back
   import mtm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_head_type q_head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic [FIELD_W-1:0] rsp_read_value,
   output logic              rsp_out_of_range
);

   logic [DATA_WIDTH-1:0] mem_ff [MEM_DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic                  stage_valid_ff, stage_valid_in;
   logic                  stage_oor_ff;
   rsp_type               rsp_buf_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [RSP_CNT_W-1:0]  pending;
   logic                  is_write, issue, issue_result, rsp_take;
   rsp_type               rsp_new;

   always_comb begin
      is_write       = (q_head.cmd.kind == CMD_WRITE);
      pending        = rsp_count_ff + RSP_CNT_W'(stage_valid_ff);
      issue          = q_head.valid && (is_write || (pending < RSP_CNT_W'(RSP_DEPTH)));
      issue_result   = issue && !is_write;
      q_pop          = issue;
      stage_valid_in = issue_result;
   end

   // single port element memory
   always_ff @(posedge clock) begin
      if (issue && is_write) begin
         mem_ff[q_head.cmd.addr] <= q_head.cmd.data;
      end
      if (issue && (q_head.cmd.kind == CMD_READ)) begin
         rdata_ff <= mem_ff[q_head.cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (issue_result) begin
         stage_oor_ff <= (q_head.cmd.kind == CMD_OOR);
      end
   end

   always_comb begin
      rsp_new.oor  = stage_oor_ff;
      rsp_new.data = stage_oor_ff ? '0 : rdata_ff;
      rsp_take     = rsp_pop && (rsp_count_ff != '0);
      wr_ptr_in    = stage_valid_ff ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = rsp_take ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      rsp_count_in = rsp_count_ff + RSP_CNT_W'(stage_valid_ff) - RSP_CNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         rsp_count_ff   <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         rsp_buf_ff[wr_ptr_ff] <= rsp_new;
      end
   end

   assign rsp_empty        = (rsp_count_ff == '0);
   assign rsp_read_value   = FIELD_W'(rsp_buf_ff[rd_ptr_ff].data);
   assign rsp_out_of_range = rsp_buf_ff[rd_ptr_ff].oor;

   `MTM_ASSERT_ALWAYS(a_rsp_credit, clock, reset, pending <= RSP_CNT_W'(RSP_DEPTH))
   `MTM_ASSERT_NEXT(a_read_lands, clock, reset, issue_result, stage_valid_ff)
   `MTM_ASSERT_IMPLIES(a_oor_zero, clock, reset, !rsp_empty && rsp_out_of_range, rsp_read_value == '0)

endmodule

`default_nettype wire

// File: hw/rtl/mirror_tile_matrix_unit.sv
// top level of the mirror tile matrix unit
//
// Holds a source matrix of up to MAX_ROWS by MAX_COLS words and answers reads of
// the 3m by 3n mosaic around it, built from mirrored copies of the source.
// Config: csr_valid/csr_ready with csr_index (0 = rows, 1 = cols) and csr_data;
// csr_ready is always high, other indexes are ignored. Write only while idle.
// Requests: an item transfers when req_push is high and req_full is low.
// Opcode 0 stores one element (no result), opcode 1 reads one mosaic element.
// Results: while rsp_empty is low the oldest result is on rsp_read_value and
// rsp_out_of_range; it transfers when rsp_pop is high.
// A read passes the command queue, the read stage and the result buffer in turn.
// Throughput: one item per cycle while results drain, set by the single port of
// the element memory and the one-per-cycle read stage behind a four-entry
// command queue. When the receiver stalls, up to four results wait in the result
// buffer, then four more items fill the command queue and req_full rises.
// Reset clears both queues and sets rows and cols to zero; the element memory
// is not cleared and an element must be written before it is read.
`default_nettype none

module mirror_tile_matrix_unit
   import mtm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_CFG_W-1:0] csr_data,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic                 req_opcode,
   input  wire logic [COORD_W-1:0]   req_row,
   input  wire logic [COORD_W-1:0]   req_col,
   input  wire logic [FIELD_W-1:0]   req_element_value,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [FIELD_W-1:0]        rsp_read_value,
   output logic                      rsp_out_of_range
);

   logic         q_full;
   logic         q_push;
   cmd_type      q_cmd;
   cmd_head_type q_head;
   logic         q_pop;

   mtm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_element_value (req_element_value),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (q_cmd)
   );

   mtm_cmd_queue u_cmd_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .cmd_in (q_cmd),
      .full   (q_full),
      .head   (q_head),
      .pop    (q_pop)
   );

   mtm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_read_value   (rsp_read_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

`default_nettype wire
